// ----- sv/lte_pkg.sv -----
// ---------------------------------------------------------------------------
// lte_pkg
// Shared types and constants for the lease table engine.
// ---------------------------------------------------------------------------
package lte_pkg;

  localparam int unsigned MaxLeasesDef = 64;
  localparam int unsigned MacW   = 48;
  localparam int unsigned TimeW  = 32;
  localparam int unsigned StW    = 2;
  localparam int unsigned SlotW  = 6;
  localparam int unsigned CntW   = 7;
  localparam int unsigned SecW   = 23;
  localparam int unsigned CfgW   = 32;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [2:0] CmdFind  = 3'd0;
  localparam logic [2:0] CmdWrite = 3'd1;
  localparam logic [2:0] CmdSwap  = 3'd2;
  localparam logic [2:0] CmdClear = 3'd3;
  localparam logic [2:0] CmdRead  = 3'd4;

  localparam logic [CfgIdxW-1:0] RegLeaseCount  = 2'd0;
  localparam logic [CfgIdxW-1:0] RegServerIp    = 2'd1;
  localparam logic [CfgIdxW-1:0] RegSubnetMask  = 2'd2;
  localparam logic [CfgIdxW-1:0] RegStartOffset = 2'd3;

  // One table entry as it travels around the ring.
  typedef struct packed {
    logic [MacW-1:0]         mac;
    logic signed [TimeW-1:0] expiry;
    logic [StW-1:0]          st;
  } entry_t;

  // Per-cycle control broadcast to every cell.
  typedef struct packed {
    logic shift;     // rotate ring by one
    logic age;       // clear state of expired entries at head
    logic load;      // replace head entry with wdata
    entry_t wdata;
    logic signed [TimeW-1:0] now;
  } cell_ctl_t;

endpackage

// ----- sv/lte_cell.sv -----
// ---------------------------------------------------------------------------
// lte_cell
// One ring stage holding one table entry.
// ---------------------------------------------------------------------------
module lte_cell
  import lte_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cell_ctl_t ctl_i,
  input  logic      is_head_i,
  input  entry_t    prev_i,
  output entry_t    ent_o
);

  entry_t ent_q, ent_d;

  always_comb begin
    ent_d = ent_q;
    if (ctl_i.shift) begin
      ent_d = prev_i;
      if (is_head_i && ctl_i.age && prev_i.mac != '0 && prev_i.expiry < ctl_i.now) begin
        ent_d.st = '0;
      end
      if (is_head_i && ctl_i.load) begin
        ent_d = ctl_i.wdata;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_q <= '0;
    end else begin
      ent_q <= ent_d;
    end
  end

  assign ent_o = ent_q;

endmodule

// ----- sv/lte_div.sv -----
// ---------------------------------------------------------------------------
// lte_div
// Divide of a 32-bit magnitude by 1000 via registered reciprocal multiply.
// ---------------------------------------------------------------------------
module lte_div
  import lte_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            go_i,
  input  logic [TimeW:0]  num_i,
  output logic            done_o,
  output logic [SecW-1:0] quo_o
);

  localparam int unsigned NumW  = TimeW + 1;
  localparam int unsigned RecW  = 29;
  localparam int unsigned ProdW = NumW + RecW;
  // ceil(2^38 / 1000); exact floor for every magnitude below 2^32
  localparam logic [RecW-1:0] Recip = 29'd274877907;
  localparam int unsigned     Shift = 38;

  logic [NumW-1:0]  num_q;
  logic [ProdW-1:0] prod_q;
  logic             vld_q, done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      vld_q  <= go_i;
      done_q <= vld_q;
    end
  end

  // stage 1 holds the operand, stage 2 the product
  always_ff @(posedge clk_i) begin
    if (go_i) num_q <= num_i;
    if (vld_q) prod_q <= ProdW'(num_q) * ProdW'(Recip);
  end

  assign done_o = done_q;
  assign quo_o  = prod_q[Shift +: SecW];

endmodule

// ----- sv/lease_table_engine.sv -----
// ---------------------------------------------------------------------------
// lease_table_engine
// Lease table kept in a rotating ring of cells; commands run one at a time.
// ---------------------------------------------------------------------------
//   channel   signals                              direction
//   command   start, busy, cmd_i .. now_ms_i       in, taken when start & !busy
//   result    done_o, found_o .. ip_addr_o         out, one-cycle strobe
//   config    cfg_we_i, cfg_idx_i, cfg_wdata_i     in, written on cfg_we_i
//
// The table lives in a ring of MAX_LEASES cells that rotates one slot a cycle
// while a lap runs; the head cell always holds the slot whose number is in
// rot_q. Every command rotates the ring once around. A find that misses, and
// a swap with both slots in range, go round a second time (age out / write
// back). A read then runs a two-stage reciprocal divide for seconds. Busy
// drops with the result strobe. Reset clears the whole ring at once; results
// cannot be stalled.
// ---------------------------------------------------------------------------
module lease_table_engine
  import lte_pkg::*;
#(
  parameter int unsigned MAX_LEASES = MaxLeasesDef
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start,
  output logic                    busy,
  input  logic [2:0]              cmd_i,
  input  logic [MacW-1:0]         mac_addr_i,
  input  logic [SlotW-1:0]        slot_a_i,
  input  logic [SlotW-1:0]        slot_b_i,
  input  logic signed [TimeW-1:0] expiry_time_i,
  input  logic [StW-1:0]          lease_state_i,
  input  logic signed [TimeW-1:0] now_ms_i,
  input  logic                    cfg_we_i,
  input  logic [CfgIdxW-1:0]      cfg_idx_i,
  input  logic [CfgW-1:0]         cfg_wdata_i,
  output logic                    done_o,
  output logic                    found_o,
  output logic [SlotW-1:0]        slot_out_o,
  output logic                    entry_used_o,
  output logic [MacW-1:0]         mac_out_o,
  output logic [StW-1:0]          state_out_o,
  output logic                    expired_o,
  output logic [SecW-1:0]         seconds_o,
  output logic [31:0]             ip_addr_o
);

  localparam int unsigned RotW = (MAX_LEASES > 1) ? $clog2(MAX_LEASES) : 1;

  // sequencer phases
  localparam logic [2:0] PhIdle = 3'd0;
  localparam logic [2:0] PhScan = 3'd1;  // first lap: match / capture / write
  localparam logic [2:0] PhAge  = 3'd2;  // second lap after find miss, or swap write-back
  localparam logic [2:0] PhDiv  = 3'd3;  // read: divide
  localparam logic [2:0] PhDone = 3'd4;

  // config
  logic [CntW-1:0] lease_count_q;
  logic [31:0]     server_ip_q, subnet_mask_q;
  logic [7:0]      start_offset_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lease_count_q  <= CntW'(64);
      server_ip_q    <= '0;
      subnet_mask_q  <= 32'hFFFF_FF00;
      start_offset_q <= 8'd1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegLeaseCount:  lease_count_q  <= cfg_wdata_i[CntW-1:0];
        RegServerIp:    server_ip_q    <= cfg_wdata_i;
        RegSubnetMask:  subnet_mask_q  <= cfg_wdata_i;
        RegStartOffset: start_offset_q <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  // effective count, saturated at MAX_LEASES
  logic [8:0] n_eff;
  assign n_eff = ({2'b0, lease_count_q} > 9'(MAX_LEASES)) ? 9'(MAX_LEASES)
                                                          : {2'b0, lease_count_q};

  // captured command
  logic [2:0]              cmd_q;
  logic [MacW-1:0]         mac_q;
  logic [SlotW-1:0]        sa_q, sb_q;
  logic signed [TimeW-1:0] exp_q, now_q;
  logic [StW-1:0]          st_q;
  entry_t                  ea_q, eb_q;   // captured entries of slot a / b
  logic                    hit_q;
  logic [SlotW-1:0]        hit_slot_q;

  logic [2:0]      ph_q, ph_d;
  logic [RotW-1:0] rot_q;     // slot number now at the head cell
  logic [8:0]      lap_q;     // steps taken in current lap

  logic accept;
  assign accept = start && !busy;
  assign busy   = (ph_q != PhIdle);

  // ring
  cell_ctl_t ctl;
  entry_t    ring [MAX_LEASES];
  entry_t    head;            // entry entering the head cell this cycle
  logic [RotW-1:0] nslot;     // slot number of that entry

  assign head  = ring[MAX_LEASES-1];
  assign nslot = (32'(rot_q) == MAX_LEASES - 1) ? '0 : RotW'(rot_q + 1'b1);

  logic in_a, in_b, sa_ok, sb_ok;
  assign sa_ok = {3'b0, sa_q} < n_eff;
  assign sb_ok = {3'b0, sb_q} < n_eff;
  assign in_a  = (32'(nslot) == 32'(sa_q));
  assign in_b  = (32'(nslot) == 32'(sb_q));

  always_comb begin
    ctl = '0;
    ctl.now = now_q;
    ctl.shift = (ph_q == PhScan) || (ph_q == PhAge);
    ctl.age = (ph_q == PhAge) && ({1'b0, 8'(nslot)} < n_eff);
    if (ph_q == PhScan) begin
      case (cmd_q)
        CmdWrite: begin
          ctl.load = in_a && sa_ok;
          ctl.wdata = '{mac: mac_q, expiry: exp_q, st: st_q};
        end
        CmdClear: ctl.load = in_a && sa_ok;
        default: ;
      endcase
    end
    // swap writes the two captured entries back on the second lap: slot a
    // takes entry b and slot b takes entry a, both with state cleared
    if (ph_q == PhAge && cmd_q == CmdSwap) begin
      ctl.age = 1'b0;
      if (in_a) begin
        ctl.load = 1'b1; ctl.wdata = '{mac: eb_q.mac, expiry: eb_q.expiry, st: '0};
      end else if (in_b) begin
        ctl.load = 1'b1; ctl.wdata = '{mac: ea_q.mac, expiry: ea_q.expiry, st: '0};
      end
    end
  end

  for (genvar g = 0; g < MAX_LEASES; g++) begin : g_cell
    entry_t prev;
    if (g == 0) begin : g_h
      assign prev = ring[MAX_LEASES-1];
    end else begin : g_b
      assign prev = ring[g-1];
    end
    lte_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctl_i    (ctl),
      .is_head_i(g == 0),
      .prev_i   (prev),
      .ent_o    (ring[g])
    );
  end

  // ring[0] holds slot rot_q; the entry moving into it is slot nslot.
  logic last_step;
  assign last_step = (lap_q == 9'(MAX_LEASES - 1));

  // slot a may be the last one to pass the head: take it live in that case
  entry_t ea_now;
  assign ea_now = (in_a && ph_q == PhScan) ? head : ea_q;

  // divider
  logic signed [TimeW:0] diff;
  logic [TimeW:0]        mag;
  logic                  div_go, div_done;
  logic [SecW-1:0]       quo;
  entry_t                rd_e;
  assign rd_e   = sa_ok ? ea_now : '0;
  assign diff   = {rd_e.expiry[TimeW-1], rd_e.expiry} - {now_q[TimeW-1], now_q};
  assign mag    = diff[TimeW] ? (TimeW+1)'(-diff) : diff;
  assign div_go = (ph_q == PhScan) && last_step && (cmd_q == CmdRead);

  lte_div u_div (
    .clk_i (clk_i), .rst_ni(rst_ni),
    .go_i  (div_go), .num_i(mag),
    .done_o(div_done), .quo_o(quo)
  );

  always_comb begin
    ph_d = ph_q;
    case (ph_q)
      PhIdle: if (accept) ph_d = PhScan;
      PhScan: if (last_step) begin
        if (cmd_q == CmdRead) ph_d = PhDiv;
        else if (cmd_q == CmdSwap && sa_ok && sb_ok) ph_d = PhAge;
        else if (cmd_q == CmdFind && !hit_q && !(head.mac == mac_q
                 && {1'b0, 8'(nslot)} < n_eff)) ph_d = PhAge;
        else ph_d = PhDone;
      end
      PhAge:  if (last_step) ph_d = PhDone;
      PhDiv:  if (div_done) ph_d = PhDone;
      PhDone: ph_d = PhIdle;
      default: ph_d = PhIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q <= PhIdle; rot_q <= '0; lap_q <= '0; hit_q <= 1'b0;
    end else begin
      ph_q <= ph_d;
      if (ctl.shift) rot_q <= nslot;
      if (ph_q != ph_d) lap_q <= '0;
      else if (ctl.shift) lap_q <= lap_q + 9'd1;
      if (accept) hit_q <= 1'b0;
      else if (ph_q == PhScan && cmd_q == CmdFind && !hit_q && head.mac == mac_q
               && {1'b0, 8'(nslot)} < n_eff) hit_q <= 1'b1;
    end
  end

  // captured command and entries (payload)
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= cmd_i; mac_q <= mac_addr_i; sa_q <= slot_a_i; sb_q <= slot_b_i;
      exp_q <= expiry_time_i; st_q <= lease_state_i; now_q <= now_ms_i;
    end
    if (ph_q == PhScan) begin
      ea_q <= ea_now;
      if (in_b) eb_q <= head;
      // first match wins: the scan starts at slot nslot and wraps, so keep
      // the lowest slot number seen
      if (cmd_q == CmdFind && head.mac == mac_q && {1'b0, 8'(nslot)} < n_eff
          && (!hit_q || nslot < hit_slot_q)) hit_slot_q <= nslot;
    end
  end

  // results
  logic [31:0] base;
  logic [7:0]  low;
  assign base = server_ip_q & subnet_mask_q;
  assign low  = base[7:0] + 8'({2'b0, sa_q}) + start_offset_q;

  logic done_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) done_q <= 1'b0;
    else done_q <= (ph_q == PhDone);
  end

  always_ff @(posedge clk_i) begin
    if (ph_q == PhDone) begin
      found_o <= 1'b0; slot_out_o <= '0; entry_used_o <= 1'b0; mac_out_o <= '0;
      state_out_o <= '0; expired_o <= 1'b0; seconds_o <= '0; ip_addr_o <= '0;
      if (cmd_q == CmdFind && hit_q) begin
        found_o <= 1'b1; slot_out_o <= hit_slot_q;
      end
      if (cmd_q == CmdRead) begin
        entry_used_o <= rd_e.mac != '0;
        mac_out_o    <= rd_e.mac;
        state_out_o  <= rd_e.st;
        expired_o    <= !(rd_e.expiry > now_q);
        seconds_o    <= quo;
        ip_addr_o    <= {base[31:8], low};
      end
    end
  end

  assign done_o = done_q;

  // a find result can only report a slot inside the active range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && found_o |-> {3'b0, slot_out_o} < n_eff)
    else $error("find slot out of range");
  // results come only after a command was in flight
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy))
    else $error("result without command");
  // the ring only rotates while a command runs
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy |=> $stable(rot_q) || $past(busy))
    else $error("ring moved while idle");

endmodule

// ----- bench/lease_table_engine_tb.sv -----
// ---------------------------------------------------------------------------
// lease_table_engine_tb
// Self-checking bench for the lease table engine. A directed table covers the
// extremes and the corner commands, then random command streams run under
// several register settings. A behavioral model predicts each untyped beat,
// and the monitor compares each done strobe field by field.
// ---------------------------------------------------------------------------
module lease_table_engine_tb;
  import lte_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Slots = MaxLeasesDef;

  // One command beat.
  typedef struct {
    logic [2:0]              cmd;
    logic [MacW-1:0]         mac;
    logic [SlotW-1:0]        sa;
    logic [SlotW-1:0]        sb;
    logic signed [TimeW-1:0] expiry;
    logic [StW-1:0]          st;
    logic signed [TimeW-1:0] now;
  } lease_cmd_t;

  // One result beat.
  typedef struct {
    logic            found;
    logic [SlotW-1:0] slot;
    logic            used;
    logic [MacW-1:0] mac;
    logic [StW-1:0]  st;
    logic            expired;
    logic [SecW-1:0] secs;
    logic [31:0]     ip;
  } lease_res_t;

  // Directed row: typed rows carry their own expected beat.
  typedef struct {
    lease_cmd_t c;
    bit         typed;
    lease_res_t want;
  } dir_row_t;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    start = 1'b0;
  logic                    busy;
  logic [2:0]              cmd_i = CmdRead;
  logic [MacW-1:0]         mac_addr_i = '0;
  logic [SlotW-1:0]        slot_a_i = '0;
  logic [SlotW-1:0]        slot_b_i = '0;
  logic signed [TimeW-1:0] expiry_time_i = '0;
  logic [StW-1:0]          lease_state_i = '0;
  logic signed [TimeW-1:0] now_ms_i = '0;
  logic                    cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]      cfg_idx_i = RegLeaseCount;
  logic [CfgW-1:0]         cfg_wdata_i = '0;
  logic                    done_o;
  logic                    found_o;
  logic [SlotW-1:0]        slot_out_o;
  logic                    entry_used_o;
  logic [MacW-1:0]         mac_out_o;
  logic [StW-1:0]          state_out_o;
  logic                    expired_o;
  logic [SecW-1:0]         seconds_o;
  logic [31:0]             ip_addr_o;

  lease_table_engine u_top (.*);

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Shadow table and register copy.
  logic [MacW-1:0]         shadow_mac [Slots];
  logic signed [TimeW-1:0] shadow_exp [Slots];
  logic [StW-1:0]          shadow_st  [Slots];
  logic [CntW-1:0]         reg_count = 7'd64;
  logic [31:0]             reg_ip    = 32'h0;
  logic [31:0]             reg_mask  = 32'hFFFF_FF00;
  logic [7:0]              reg_off   = 8'd1;

  lease_res_t pending_beats [$];
  bit         failed = 1'b0;
  bit         quiet  = 1'b0;
  logic [MacW-1:0] mac_pool [8];
  int         time_base = 0;

  // Runs one command against the shadow table; returns the beat it causes.
  function automatic lease_res_t lease_apply(lease_cmd_t c);
    lease_res_t              r;
    int unsigned             n;
    logic [MacW-1:0]         tm;
    logic signed [TimeW-1:0] te;
    longint                  diff;
    logic [31:0]             base;
    bit                      hit;
    r = '{default: '0};
    n = (reg_count > Slots) ? Slots : 32'(reg_count);
    hit = 1'b0;
    case (c.cmd)
      CmdFind: begin
        for (int i = 0; i < n; i++) begin
          if (!hit && shadow_mac[i] == c.mac) begin
            hit = 1'b1;
            r.found = 1'b1;
            r.slot = SlotW'(i);
          end
        end
        // miss: age out expired, nonblank leases
        if (!hit) begin
          for (int i = 0; i < n; i++)
            if (shadow_mac[i] != 0 && shadow_exp[i] < c.now) shadow_st[i] = 2'd0;
        end
      end
      CmdWrite: begin
        if (c.sa < n) begin
          shadow_mac[c.sa] = c.mac;
          shadow_exp[c.sa] = c.expiry;
          shadow_st[c.sa]  = c.st;
        end
      end
      CmdSwap: begin
        if (c.sa < n && c.sb < n) begin
          tm = shadow_mac[c.sa];
          te = shadow_exp[c.sa];
          shadow_mac[c.sa] = shadow_mac[c.sb];
          shadow_exp[c.sa] = shadow_exp[c.sb];
          shadow_mac[c.sb] = tm;
          shadow_exp[c.sb] = te;
          shadow_st[c.sa] = 2'd0;
          shadow_st[c.sb] = 2'd0;
        end
      end
      CmdClear: begin
        if (c.sa < n) begin
          shadow_mac[c.sa] = '0;
          shadow_exp[c.sa] = '0;
          shadow_st[c.sa]  = '0;
        end
      end
      CmdRead: begin
        te = '0;
        if (c.sa < n) begin
          r.mac = shadow_mac[c.sa];
          r.st  = shadow_st[c.sa];
          te    = shadow_exp[c.sa];
        end
        r.used = (r.mac != 0);
        r.expired = !(te > c.now);
        diff = longint'(te) - longint'(c.now);
        if (diff < 0) diff = -diff;
        r.secs = SecW'(diff / 1000);
        base = reg_ip & reg_mask;
        r.ip = {base[31:8], 8'(base[7:0] + 8'(c.sa) + reg_off)};
      end
      default: ;
    endcase
    return r;
  endfunction

  // Drives one command beat; typed rows push their own expectation.
  task automatic issue(lease_cmd_t c, bit typed = 1'b0, lease_res_t want = '{default: '0});
    lease_res_t r;
    if (!quiet && $urandom_range(0, 2) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    start         <= 1'b1;
    cmd_i         <= c.cmd;
    mac_addr_i    <= c.mac;
    slot_a_i      <= c.sa;
    slot_b_i      <= c.sb;
    expiry_time_i <= c.expiry;
    lease_state_i <= c.st;
    now_ms_i      <= c.now;
    do @(posedge clk_i); while (busy);
    r = lease_apply(c);
    pending_beats.push_back(typed ? want : r);
  endtask

  // Waits out every pending beat, then writes one register while idle.
  task automatic cfg_write(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] val);
    start <= 1'b0;
    wait (pending_beats.size() == 0);
    repeat (2 * Slots + 8) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      RegLeaseCount:  reg_count = val[CntW-1:0];
      RegServerIp:    reg_ip    = val;
      RegSubnetMask:  reg_mask  = val;
      RegStartOffset: reg_off   = val[7:0];
      default: ;
    endcase
  endtask

  function automatic lease_cmd_t rand_cmd();
    lease_cmd_t  c;
    int unsigned pick;
    int unsigned lim;
    pick = $urandom_range(0, 99);
    if (pick < 25)      c.cmd = CmdFind;
    else if (pick < 50) c.cmd = CmdWrite;
    else if (pick < 75) c.cmd = CmdRead;
    else if (pick < 85) c.cmd = CmdSwap;
    else if (pick < 95) c.cmd = CmdClear;
    else                c.cmd = 3'($urandom_range(5, 7));
    // mostly a small pool of MACs so finds hit, with blanks and noise
    pick = $urandom_range(0, 9);
    if (pick == 0)      c.mac = '0;
    else if (pick == 1) c.mac = MacW'({$urandom(), $urandom()});
    else                c.mac = mac_pool[$urandom_range(0, 7)];
    // slots mostly inside the active range, sometimes just past it
    lim = (reg_count > 61) ? 63 : 32'(reg_count) + 2;
    if ($urandom_range(0, 7) == 0) lim = 63;
    c.sa = SlotW'($urandom_range(0, lim));
    c.sb = SlotW'($urandom_range(0, lim));
    c.st = StW'($urandom_range(0, 3));
    // times cluster round a slowly moving clock
    time_base += $urandom_range(0, 5000);
    if ($urandom_range(0, 7) == 0) begin
      c.expiry = $urandom();
      c.now    = $urandom();
    end else begin
      c.expiry = time_base + int'($urandom_range(0, 60000)) - 20000;
      c.now    = time_base;
    end
    return c;
  endfunction

  function automatic dir_row_t row(logic [2:0] cmd, logic [MacW-1:0] mac, int sa, int sb,
                                   int ex, int st, int now);
    dir_row_t d;
    d.c = '{cmd, mac, 6'(sa), 6'(sb), ex, 2'(st), now};
    d.typed = 1'b0;
    d.want = '{default: '0};
    return d;
  endfunction

  // Result monitor: every done strobe is one beat.
  always @(posedge clk_i) begin
    lease_res_t w;
    if (rst_ni && done_o) begin
      if (pending_beats.size() == 0) begin
        $display("%0t: result beat with nothing expected", $realtime);
        failed = 1'b1;
      end else begin
        w = pending_beats.pop_front();
        if (found_o !== w.found) begin
          $display("%0t: found exp %0h got %0h", $realtime, w.found, found_o);
          failed = 1'b1;
        end
        if (slot_out_o !== w.slot) begin
          $display("%0t: slot exp %0d got %0d", $realtime, w.slot, slot_out_o);
          failed = 1'b1;
        end
        if (entry_used_o !== w.used) begin
          $display("%0t: used exp %0h got %0h", $realtime, w.used, entry_used_o);
          failed = 1'b1;
        end
        if (mac_out_o !== w.mac) begin
          $display("%0t: mac exp %h got %h", $realtime, w.mac, mac_out_o);
          failed = 1'b1;
        end
        if (state_out_o !== w.st) begin
          $display("%0t: state exp %0d got %0d", $realtime, w.st, state_out_o);
          failed = 1'b1;
        end
        if (expired_o !== w.expired) begin
          $display("%0t: expired exp %0h got %0h", $realtime, w.expired, expired_o);
          failed = 1'b1;
        end
        if (seconds_o !== w.secs) begin
          $display("%0t: seconds exp %0d got %0d", $realtime, w.secs, seconds_o);
          failed = 1'b1;
        end
        if (ip_addr_o !== w.ip) begin
          $display("%0t: ip exp %h got %h", $realtime, w.ip, ip_addr_o);
          failed = 1'b1;
        end
      end
    end
  end

  initial begin
    #20ms;
    $display("Verification failed");
    $finish;
  end

  initial begin
    dir_row_t   dir_rows [$];
    dir_row_t   d;
    lease_res_t zero_beat;
    int         last_cnt;
    for (int i = 0; i < Slots; i++) begin
      shadow_mac[i] = '0;
      shadow_exp[i] = '0;
      shadow_st[i]  = '0;
    end
    mac_pool = '{48'hFFFF_FFFF_FFFF, 48'h0000_0000_0001, 48'hAAAA_5555_AAAA,
                 48'h5555_AAAA_5555, 48'h8000_0000_0000, 48'h0012_3456_789A,
                 48'h00DE_ADBE_EF00, 48'hF0F0_0F0F_F0F0};
    zero_beat = '{default: '0};

    // Directed table. Fresh after reset: slot 0 blank, expiry 0, low byte 1.
    d = row(CmdRead, 0, 0, 0, 0, 0, 0);
    d.typed = 1'b1;
    d.want = '{default: '0};
    d.want.expired = 1'b1;
    d.want.ip = 32'h0000_0001;
    dir_rows.push_back(d);
    // zero MAC finds the first free slot
    d = row(CmdFind, 0, 0, 0, 0, 0, 0);
    d.typed = 1'b1;
    d.want = '{default: '0};
    d.want.found = 1'b1;
    dir_rows.push_back(d);
    dir_rows.push_back(row(CmdWrite, 48'hFFFF_FFFF_FFFF, 0, 0, 32'h7FFF_FFFF, 2, 0));
    dir_rows.push_back(row(CmdWrite, 48'h0000_0000_0001, 63, 0, 32'h8000_0000, 3, 0));
    dir_rows.push_back(row(CmdWrite, 48'hAAAA_5555_AAAA, 5, 0, 1000, 1, 0));
    dir_rows.push_back(row(CmdRead, 0, 0, 0, 0, 0, 32'h8000_0000));
    dir_rows.push_back(row(CmdRead, 0, 63, 0, 0, 0, 32'h7FFF_FFFF));
    // full MAC finds slot 0
    d = row(CmdFind, 48'hFFFF_FFFF_FFFF, 0, 0, 0, 0, 0);
    d.typed = 1'b1;
    d.want = '{default: '0};
    d.want.found = 1'b1;
    dir_rows.push_back(d);
    // miss at the latest time ages out every nonblank lease expiring before it
    dir_rows.push_back(row(CmdFind, 48'h1234_5678_9ABC, 0, 0, 0, 0, 32'h7FFF_FFFF));
    dir_rows.push_back(row(CmdRead, 0, 5, 0, 0, 0, 999));
    dir_rows.push_back(row(CmdWrite, 48'h5555_AAAA_5555, 5, 0, -5000, 2, 0));
    dir_rows.push_back(row(CmdSwap, 0, 0, 63, 0, 0, 0));
    dir_rows.push_back(row(CmdRead, 0, 63, 0, 0, 0, -1));
    dir_rows.push_back(row(CmdSwap, 0, 5, 5, 0, 0, 0));
    dir_rows.push_back(row(CmdRead, 0, 5, 0, 0, 0, -5000));
    dir_rows.push_back(row(CmdClear, 0, 63, 0, 0, 0, 0));
    dir_rows.push_back(row(CmdRead, 0, 63, 0, 0, 0, 1500));
    // unknown commands leave the table alone and return a zero beat
    for (int k = 5; k < 8; k++) begin
      d = row(3'(k), 48'hFFFF_FFFF_FFFF, 63, 63, -1, 3, -1);
      d.typed = 1'b1;
      d.want = zero_beat;
      dir_rows.push_back(d);
    end
    dir_rows.push_back(row(CmdFind, 48'h5555_AAAA_5555, 0, 0, 0, 0, 0));
    dir_rows.push_back(row(CmdRead, 0, 0, 0, 0, 0, 0));

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[k]) issue(dir_rows[k].c, dir_rows[k].typed, dir_rows[k].want);

    // Random phases, each under its own register setting.
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: ;
        1: begin
          cfg_write(RegLeaseCount, 32'd0);
          cfg_write(RegServerIp, 32'hFFFF_FFFF);
          cfg_write(RegSubnetMask, 32'hFFFF_FFFF);
          cfg_write(RegStartOffset, 32'd255);
        end
        2: begin
          cfg_write(RegLeaseCount, 32'd1);
          cfg_write(RegServerIp, 32'hC0A8_01FE);
          cfg_write(RegSubnetMask, 32'h0);
          cfg_write(RegStartOffset, 32'd0);
        end
        3: begin
          // past the slot count: saturates
          cfg_write(RegLeaseCount, 32'd127);
          cfg_write(RegServerIp, $urandom());
          cfg_write(RegSubnetMask, 32'hFFFF_FF00);
          cfg_write(RegStartOffset, $urandom_range(0, 255));
        end
        4: begin
          cfg_write(RegLeaseCount, $urandom_range(2, 63));
          cfg_write(RegServerIp, $urandom());
          cfg_write(RegSubnetMask, $urandom());
          cfg_write(RegStartOffset, $urandom_range(0, 255));
        end
        default: begin
          cfg_write(RegLeaseCount, 32'd64);
          quiet = 1'b1;
        end
      endcase
      last_cnt = (ph == 1) ? 60 : 230;
      for (int k = 0; k < last_cnt; k++) issue(rand_cmd());
    end

    start <= 1'b0;
    fork
      wait (pending_beats.size() == 0);
      repeat (400 * Slots) @(posedge clk_i);
    join_any
    disable fork;
    repeat (2 * Slots + 8) @(posedge clk_i);
    if (!failed && pending_beats.size() == 0) begin
      $display("Verification passed");
    end else begin
      if (pending_beats.size() != 0)
        $display("%0t: %0d result beats never arrived", $realtime, pending_beats.size());
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
sv/lte_pkg.sv
sv/lte_cell.sv
sv/lte_div.sv
sv/lease_table_engine.sv
bench/lease_table_engine_tb.sv
